// ===== sv/hkv_pkg.sv =====
package hkv_pkg;

   // table geometry
   localparam int BUCKETS     = 64;
   localparam int WAYS        = 4;
   localparam int KEY_BITS    = 32;
   localparam int VALUE_BITS  = 32;

   // field widths of the channels
   localparam int KEY_WIDTH   = 32;
   localparam int VALUE_WIDTH = 32;
   localparam int ENTRY_WIDTH = 9;
   localparam int KIND_WIDTH  = 2;

   localparam int SLOTS       = BUCKETS * WAYS;
   localparam int BUCKET_BITS = $clog2(BUCKETS);
   localparam int WAY_BITS    = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int COUNT_BITS  = $clog2(SLOTS + 1);

   // only the low KEY_BITS / VALUE_BITS of a field take part
   localparam logic [KEY_WIDTH-1:0] KEY_MASK = (KEY_BITS >= KEY_WIDTH) ?
      {KEY_WIDTH{1'b1}} : KEY_WIDTH'((64'd1 << KEY_BITS) - 64'd1);
   localparam logic [VALUE_WIDTH-1:0] VALUE_MASK = (VALUE_BITS >= VALUE_WIDTH) ?
      {VALUE_WIDTH{1'b1}} : VALUE_WIDTH'((64'd1 << VALUE_BITS) - 64'd1);

   // request kinds; the unused code behaves as a lookup
   localparam logic [KIND_WIDTH-1:0] KIND_LOOKUP = 2'd0;
   localparam logic [KIND_WIDTH-1:0] KIND_PUT    = 2'd1;
   localparam logic [KIND_WIDTH-1:0] KIND_REMOVE = 2'd2;

   typedef struct packed {
      logic [KIND_WIDTH-1:0]  kind;
      logic [KEY_WIDTH-1:0]   key;
      logic [VALUE_WIDTH-1:0] value;
   } hkv_req_type;

   typedef struct packed {
      logic                   found;
      logic [VALUE_WIDTH-1:0] value_out;
      logic                   full_res;
      logic [ENTRY_WIDTH-1:0] entry_count;
   } hkv_rsp_type;

   // one slot of a bucket row as held in the row memory
   typedef struct packed {
      logic [KEY_WIDTH-1:0]   key;
      logic [VALUE_WIDTH-1:0] value;
   } hkv_slot_type;

   typedef hkv_slot_type [WAYS-1:0] hkv_row_type;

   localparam int ROW_WIDTH = $bits(hkv_row_type);

   // controller to datapath commands
   typedef struct packed {
      logic capture;
      logic commit;
   } hkv_cmd_type;

endpackage

// ===== sv/hkv_ram.sv =====
module hkv_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/hkv_ctrl.sv =====
module hkv_ctrl import hkv_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output hkv_cmd_type cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_UPDATE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      out_free;

   // one item in flight: take it, then read its bucket row and update
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign cmd.capture = accept;
   assign cmd.commit  = (state_ff == ST_UPDATE) && out_free;

   // next state and result valid
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (out_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== sv/hkv_datapath.sv =====
module hkv_datapath import hkv_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  hkv_cmd_type cmd,
   input  hkv_req_type req_item,
   output hkv_rsp_type rsp_item
);

   hkv_req_type                 req_ff;
   hkv_rsp_type                 rsp_ff, rsp_in;
   logic [WAYS-1:0]             valid_ff [BUCKETS];
   logic [COUNT_BITS-1:0]       count_ff, count_in;

   logic [KEY_WIDTH-1:0]        in_key;
   logic [BUCKET_BITS-1:0]      rd_bucket;
   logic [KEY_WIDTH-1:0]        key;
   logic [VALUE_WIDTH-1:0]      value;
   logic [BUCKET_BITS-1:0]      bucket;
   logic [ROW_WIDTH-1:0]        rd_data;
   hkv_row_type                 row;
   hkv_row_type                 row_in;
   logic [WAYS-1:0]             vld;
   logic [WAYS-1:0]             hit_vec;
   logic                        hit;
   logic [WAY_BITS-1:0]         hit_way;
   logic                        has_free;
   logic [WAY_BITS-1:0]         free_way;
   logic                        is_put;
   logic                        is_remove;
   logic                        do_insert;
   logic                        do_remove;
   logic                        wr_en;

   // bucket of the incoming item, read at capture
   assign in_key    = req_item.key & KEY_MASK;
   assign rd_bucket = in_key[BUCKET_BITS-1:0];

   assign key    = req_ff.key & KEY_MASK;
   assign value  = req_ff.value & VALUE_MASK;
   assign bucket = key[BUCKET_BITS-1:0];

   hkv_ram #(
      .WIDTH (ROW_WIDTH),
      .DEPTH (BUCKETS)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (bucket),
      .wr_data (row_in),
      .rd_en   (cmd.capture),
      .rd_addr (rd_bucket),
      .rd_data (rd_data)
   );

   assign row = hkv_row_type'(rd_data);
   assign vld = valid_ff[bucket];

   // compare all ways of the row at once
   always_comb begin
      for (int w = 0; w < WAYS; w++) begin
         hit_vec[w] = vld[w] && (row[w].key == key);
      end
   end

   // lowest matching way and lowest free way
   always_comb begin
      hit      = 1'b0;
      hit_way  = '0;
      has_free = 1'b0;
      free_way = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (hit_vec[w]) begin
            hit     = 1'b1;
            hit_way = WAY_BITS'(w);
         end
         if (!vld[w]) begin
            has_free = 1'b1;
            free_way = WAY_BITS'(w);
         end
      end
   end

   assign is_put    = (req_ff.kind == KIND_PUT);
   assign is_remove = (req_ff.kind == KIND_REMOVE);
   assign do_insert = cmd.commit && is_put && !hit && has_free;
   assign do_remove = cmd.commit && is_remove && hit;
   assign wr_en     = cmd.commit && is_put && (hit || has_free);

   // row written back: update in place or fill the free way
   always_comb begin
      row_in = row;
      if (hit) begin
         row_in[hit_way].value = value;
      end else begin
         row_in[free_way].key   = key;
         row_in[free_way].value = value;
      end
   end

   // live entry count
   always_comb begin
      priority if (do_insert) begin
         count_in = count_ff + COUNT_BITS'(1);
      end else if (do_remove) begin
         count_in = count_ff - COUNT_BITS'(1);
      end else begin
         count_in = count_ff;
      end
   end

   // result item
   always_comb begin
      rsp_in.found       = hit;
      rsp_in.value_out   = '0;
      rsp_in.full_res    = is_put && !hit && !has_free;
      rsp_in.entry_count = ENTRY_WIDTH'(count_in);
      if (!is_put && !is_remove && hit) begin
         rsp_in.value_out = row[hit_way].value;
      end
   end

   // valid marks and count
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int b = 0; b < BUCKETS; b++) begin
            valid_ff[b] <= '0;
         end
         count_ff <= '0;
      end else begin
         if (do_insert) begin
            valid_ff[bucket][free_way] <= 1'b1;
         end
         if (do_remove) begin
            valid_ff[bucket][hit_way] <= 1'b0;
         end
         count_ff <= count_in;
      end
   end

   // request and result registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_item;
      end
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_item = rsp_ff;

endmodule

// ===== sv/hash_key_value_table.sv =====
// hash_key_value_table: keyed store of key/value pairs in fixed buckets
//
// req channel (req_valid, req_stall, req_item): one item is a lookup, a put
// (insert or update) or a remove, taken when req_valid is high and req_stall
// low. rsp channel (rsp_valid, rsp_stall, rsp_item): one result per item with
// the found flag, the value on a lookup hit, the bucket-full flag of a refused
// put and the live entry count after the item.
// The bucket is the low bits of the key; each bucket holds WAYS slots kept
// as one row of a memory, whose ways are compared in parallel.
// The item is taken with the registered read of its bucket row; the compare and
// write-back step then puts the result in the output register. No new item is
// taken until that write-back is done, so one item is in progress at a time.
// A finished result waits in the output register while rsp_stall is high; the
// next item is still taken then, and its update waits until the register frees.
// Reset clears all valid marks and the entry count without a clearing pass,
// and the block takes items right after reset.
module hash_key_value_table import hkv_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  hkv_req_type req_item,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output hkv_rsp_type rsp_item
);

   hkv_cmd_type cmd;

   hkv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   hkv_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_item (req_item),
      .rsp_item (rsp_item)
   );

   // a taken item blocks the input until its update is done
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> req_stall)
      else $error("input not blocked after an item was taken");

   // never read and write back in the same cycle
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(cmd.capture && cmd.commit))
      else $error("capture and commit in the same cycle");

   // a refused put never reports a hit
   a_full_not_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.full_res |-> !rsp_item.found)
      else $error("full flag together with found");

   // a returned value needs a hit
   a_value_needs_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_item.value_out != '0) |-> rsp_item.found)
      else $error("value returned without a hit");

endmodule
